// ===== src/fqs_pkg.sv =====
// shared constants, codes and types of the searchable queue
package fqs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         match_position;
    status_e                  status;
    logic                     is_empty;
    logic [POS_W-1:0]         occupancy;
  } rsp_t;

endpackage

// ===== src/fqs_if.sv =====
// command and response channel interfaces
interface fqs_cmd_if import fqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  mode_e                    mode;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, mode, value, position, input ready);
  modport sink (input valid, mode, value, position, output ready);
endinterface

interface fqs_rsp_if import fqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         match_position;
  status_e                  status;
  logic                     is_empty;
  logic [POS_W-1:0]         occupancy;

  modport source (output valid, data_out, match_position, status, is_empty, occupancy,
                  input ready);
  modport sink (input valid, data_out, match_position, status, is_empty, occupancy,
                output ready);
endinterface

// ===== src/fqs_ctrl.sv =====
// entry memory, queue pointers and the command sequencer
module fqs_ctrl import fqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqs_cmd_if.sink    cmd_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output rsp_t       push_o
);

  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_PUSH   = 4'b1000
  } state_e;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    next_slot = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // slot of the word at offset off from base, off up to DEPTH
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [IDX_W:0] s;
    s = (IDX_W + 1)'(base) + (IDX_W + 1)'(off);
    if (s >= (IDX_W + 1)'(DEPTH)) s = s - (IDX_W + 1)'(DEPTH);
    slot_at = s[IDX_W-1:0];
  endfunction

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         head_q, head_d;
  logic [IDX_W-1:0]         tail_q, tail_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic                     pend_q, pend_d;
  logic [WORD_W-1:0]        key_q, key_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]         match_q, match_d;
  status_e                  status_q, status_d;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic              acc;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign acc         = cmd_i.valid && cmd_i.ready;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    k_d      = k_q;
    pend_d   = 1'b0;
    key_d    = key_q;
    data_d   = data_q;
    match_d  = match_q;
    status_d = status_q;
    mem_we   = 1'b0;
    mem_addr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          data_d   = '0;
          match_d  = '0;
          status_d = ST_OK;
          unique case (cmd_i.mode)
            MODE_ENQ: begin
              state_d = S_PUSH;
              if (count_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_addr = tail_q;
                tail_d   = next_slot(tail_q);
                count_d  = count_q + 1'b1;
              end
            end
            MODE_DEQ: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_PUSH;
              end else begin
                mem_addr = head_q;
                head_d   = next_slot(head_q);
                count_d  = count_q - 1'b1;
                state_d  = S_READ;
              end
            end
            MODE_FIND: begin
              if (cmd_i.position == '0 ||
                  CMP_W'(cmd_i.position) > CMP_W'(count_q)) begin
                status_d = ST_BADPOS;
                state_d  = S_PUSH;
              end else begin
                mem_addr = slot_at(head_q, CNT_W'(cmd_i.position - 1'b1));
                state_d  = S_READ;
              end
            end
            MODE_SEARCH: begin
              key_d   = cmd_i.value[WORD_W-1:0];
              k_d     = '0;
              state_d = S_SEARCH;
            end
          endcase
        end
      end
      S_READ: begin
        data_d  = DATA_W'(rdata_q);
        state_d = S_PUSH;
      end
      S_SEARCH: begin
        // k_q reads are issued; the one in flight is entry k_q - 1
        if (pend_q && rdata_q == key_q) begin
          match_d = POS_W'(k_q);
          state_d = S_PUSH;
        end else if (k_q < count_q) begin
          mem_addr = slot_at(head_q, k_q);
          k_d      = k_q + 1'b1;
          pend_d   = 1'b1;
        end else begin
          status_d = ST_NOTFOUND;
          state_d  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= cmd_i.value[WORD_W-1:0];
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    data_q   <= data_d;
    match_q  <= match_d;
    status_q <= status_d;
  end

  assign push_valid_o          = (state_q == S_PUSH);
  assign push_o.data_out       = data_q;
  assign push_o.match_position = match_q;
  assign push_o.status         = status_q;
  assign push_o.is_empty       = (count_q == '0);
  assign push_o.occupancy      = POS_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy above queue depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_at(head_q, count_q) == tail_q)
    else $error("head, tail and occupancy disagree");

  a_count_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(acc))
    else $error("occupancy changed without an accepted command");

  a_pend_has_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH && pend_q) |-> (k_q != '0))
    else $error("search compare without an issued read");

endmodule

// ===== src/fifo_queue_with_search_core.sv =====
// top level of the fifo queue with indexed peek and search
//
// commands arrive on cmd_i (valid/ready); a word is taken when both are high.
// mode selects enqueue, dequeue, find by 1-based position or search by value.
// each command gives exactly one response word on rsp_o with data, match
// position, status, and the emptiness and occupancy after the command.
// entries live in a single-port memory with a registered read.
// path from accept to the response on rsp_o:
//   enqueue and rejected commands: straight to the push state
//   dequeue and find: one memory read, then the push state
//   search: one entry compared per memory read, until a match or the occupancy is used up
// a new command is taken as soon as the response is handed to the output register.
// a response waiting in the output register does not block the next command;
// a second finished response waits in the sequencer until rsp_o is free.
// reset empties the queue; stored words are not cleared and are never read
// before being written.
module fifo_queue_with_search_core import fqs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqs_cmd_if.sink   cmd_i,
  fqs_rsp_if.source rsp_o
);

  logic push_valid;
  logic push_ready;
  rsp_t push;
  logic out_valid_q;
  rsp_t out_q;

  fqs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_o       (push)
  );

  // output register frees when empty or being taken this cycle
  assign push_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_valid && push_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid && push_ready) out_q <= push;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.data_out       = out_q.data_out;
  assign rsp_o.match_position = out_q.match_position;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.is_empty       = out_q.is_empty;
  assign rsp_o.occupancy      = out_q.occupancy;

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the fifo queue with indexed peek and search
module tb;
  import fqs_pkg::*;

  localparam int unsigned RAND_WORDS = 1700;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 50;

  // shadow copy of the queue plus the responses it still owes
  class search_queue_shadow;
    logic [DATA_W-1:0] slots[DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned count;
    rsp_t owed_rsps[$];
    int unsigned errors;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      errors = 0;
    endfunction

    function logic [DATA_W-1:0] word_at(int unsigned pos);
      return slots[(head + pos - 1) % DEPTH];
    endfunction

    function int unsigned pending();
      return owed_rsps.size();
    endfunction

    function void note_cmd(mode_e m, logic [DATA_W-1:0] v, logic [POS_W-1:0] p);
      rsp_t r;
      int unsigned k;
      bit hit;
      r = '0;
      r.status = ST_OK;
      hit = 1'b0;
      case (m)
        MODE_ENQ: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[tail] = v;
            tail = (tail + 1) % DEPTH;
            count++;
          end
        end
        MODE_DEQ: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data_out = slots[head];
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        MODE_FIND: begin
          if (p < 1 || p > count) r.status = ST_BADPOS;
          else r.data_out = word_at(p);
        end
        default: begin
          r.status = ST_NOTFOUND;
          for (k = 0; k < count && !hit; k++) begin
            if (slots[(head + k) % DEPTH] == v) begin
              hit = 1'b1;
              r.match_position = POS_W'(k + 1);
              r.status = ST_OK;
            end
          end
        end
      endcase
      r.is_empty = (count == 0);
      r.occupancy = POS_W'(count);
      owed_rsps.push_back(r);
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      bit bad;
      if (owed_rsps.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: data %h pos %0d st %0d empty %b occ %0d",
                   got.data_out, got.match_position, got.status, got.is_empty,
                   got.occupancy);
        return;
      end
      want = owed_rsps.pop_front();
      bad = (got.data_out !== want.data_out) || (got.match_position !== want.match_position)
         || (got.status !== want.status) || (got.is_empty !== want.is_empty)
         || (got.occupancy !== want.occupancy);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: want data %h pos %0d st %0d empty %b occ %0d",
                   want.data_out, want.match_position, want.status, want.is_empty,
                   want.occupancy);
          $display("          got  data %h pos %0d st %0d empty %b occ %0d",
                   got.data_out, got.match_position, got.status, got.is_empty,
                   got.occupancy);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fqs_cmd_if cmd ();
  fqs_rsp_if rsp ();

  fifo_queue_with_search_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  search_queue_shadow shadow = new();

  logic [DATA_W-1:0] seed_words[DEPTH] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000,
    32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
    32'h1357_9bdf, 32'heca8_6420, 32'h0000_0003, 32'hdead_beef,
    32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0002, 32'h8000_0001
  };

  bit drain_out = 1'b0;
  int unsigned rx_style = 0;
  int unsigned rx_left = 0;
  int unsigned rx_hold = 0;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cmd.valid = 1'b0;
    cmd.mode = MODE_ENQ;
    cmd.value = '0;
    cmd.position = '0;
    rsp.ready = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: always ready, random per cycle, or mostly ready with long stalls
  always @(negedge clk) begin
    if (drain_out) begin
      rsp.ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = $urandom_range(40, 300);
      end
      rx_left--;
      if (rx_hold != 0) begin
        rx_hold--;
        rsp.ready <= 1'b0;
      end else begin
        case (rx_style)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(1, 20);
            rsp.ready <= (rx_hold == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    if (rst_n && rsp.valid && rsp.ready) begin
      got.data_out = rsp.data_out;
      got.match_position = rsp.match_position;
      got.status = rsp.status;
      got.is_empty = rsp.is_empty;
      got.occupancy = rsp.occupancy;
      shadow.check_rsp(got);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic send_word(mode_e m, logic [DATA_W-1:0] v, logic [POS_W-1:0] p);
    @(negedge clk);
    cmd.valid <= 1'b1;
    cmd.mode <= m;
    cmd.value <= v;
    cmd.position <= p;
    do @(posedge clk); while (!cmd.ready);
    shadow.note_cmd(m, v, p);
  endtask

  // valid low with junk on the payload
  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
      cmd.mode <= mode_e'(2'($urandom_range(0, 3)));
      cmd.value <= $urandom;
      cmd.position <= POS_W'($urandom);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned i;
    int unsigned r;
    int unsigned bias;
    int unsigned burst_left;
    bit gapless;
    mode_e m;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0] p;

    burst_left = 0;
    gapless = 1'b0;
    bias = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    idle(3);

    // empty-queue cases
    send_word(MODE_DEQ, 32'h0, 5'd0);
    send_word(MODE_SEARCH, 32'h0, 5'd0);
    send_word(MODE_FIND, 32'h0, 5'd1);
    // fill up, then one more into a full queue
    for (i = 0; i < DEPTH; i++) send_word(MODE_ENQ, seed_words[i], 5'd0);
    send_word(MODE_ENQ, 32'h7777_7777, 5'd0);
    send_word(MODE_FIND, 32'h0, 5'd0);
    send_word(MODE_FIND, 32'h0, 5'd16);
    send_word(MODE_FIND, 32'h0, 5'd31);
    send_word(MODE_SEARCH, 32'h8000_0001, 5'd0);
    // duplicate key, first one wins
    send_word(MODE_SEARCH, 32'h0000_0001, 5'd0);
    send_word(MODE_SEARCH, 32'h1234_5678, 5'd0);
    send_word(MODE_DEQ, 32'h0, 5'd0);

    for (i = 0; i < RAND_WORDS; i++) begin
      if (i % 200 == 0) begin
        bias = $urandom_range(0, 2);
        gapless = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      case (bias)
        1: m = (r < 55) ? MODE_ENQ : (r < 70) ? MODE_DEQ : (r < 85) ? MODE_FIND : MODE_SEARCH;
        2: m = (r < 15) ? MODE_ENQ : (r < 70) ? MODE_DEQ : (r < 85) ? MODE_FIND : MODE_SEARCH;
        default:
          m = (r < 30) ? MODE_ENQ : (r < 55) ? MODE_DEQ : (r < 77) ? MODE_FIND : MODE_SEARCH;
      endcase
      v = pick_value();
      if (m == MODE_SEARCH && shadow.count > 0 && $urandom_range(0, 9) < 6)
        v = shadow.word_at($urandom_range(1, shadow.count));
      if (shadow.count > 0 && $urandom_range(0, 9) < 7)
        p = POS_W'($urandom_range(1, shadow.count));
      else p = POS_W'($urandom_range(0, 31));
      send_word(m, v, p);
      if (!gapless) begin
        if (burst_left == 0) begin
          idle($urandom_range(1, 8));
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end

    idle(1);
    drain_out = 1'b1;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
